[rtl/core/ihre_pkg.sv]
package ihre_pkg;

  // fixed field widths
  localparam int ADDR_W    = 16;
  localparam int FILL_W    = 5;
  localparam int CHAR_W    = 8;
  localparam int HDR_BYTES = 4;

  // default record length
  localparam int RECORD_BYTES_DEF = 16;

  localparam logic [CHAR_W-1:0] ASCII_COLON = 8'h3A;
  localparam logic [CHAR_W-1:0] ASCII_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_ALPHA = 8'h37;  // 'A' - 10

  localparam logic [7:0] TYPE_DATA = 8'h00;
  localparam logic [7:0] TYPE_EOF  = 8'h01;

  // request kinds on the input channel (code 3 behaves like ACT_END)
  typedef enum logic [1:0] {
    ACT_PUSH     = 2'd0,
    ACT_PUSH_END = 2'd1,
    ACT_END      = 2'd2
  } action_t;

  typedef enum logic [1:0] {
    CK_COLON,
    CK_HEX,
    CK_LF
  } char_kind_t;

  typedef enum logic [2:0] {
    BS_COUNT,
    BS_ADDR_HI,
    BS_ADDR_LO,
    BS_TYPE,
    BS_DATA,
    BS_SUM
  } byte_sel_t;

  // controller -> datapath
  typedef struct packed {
    logic              push;      // store input byte, bump fill
    logic              emit;      // load output register
    char_kind_t        kind;
    byte_sel_t         bsel;
    logic              nib_hi;
    logic              eof;       // current record is end-of-file
    logic [FILL_W-1:0] rd_idx;
    logic              rec_done;  // data record closed
    logic              eof_done;  // end-of-file record closed
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic              out_free;
    logic              fill_full;
    logic              fill_last;
    logic [FILL_W-1:0] fill;
  } stat_t;

  function automatic logic [CHAR_W-1:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) begin
      hex_char = ASCII_ZERO + {4'd0, nib};
    end else begin
      hex_char = ASCII_ALPHA + {4'd0, nib};
    end
  endfunction

endpackage

[rtl/core/intel_hex_record_encoder.sv]
// Intel HEX record encoder. Bytes arrive on the input stream (tuser selects push,
// push-and-end or end) and ASCII text leaves one character per request on the output
// stream. Every RECORD_BYTES bytes produce a data record ":LLAAAA00<data>CC" plus line
// feed; ending a stream flushes any partial record and then writes ":00000001FF" with a
// line feed flagged by out_tlast, after which the address reloads from the configured
// start address (a configuration write also reloads it). A byte that completes no record
// leaves the input ready for the next byte. The byte that fills a record of n data bytes
// holds the input off through a decision state, 12 + 2n characters at one per cycle from
// the output register while the receiver keeps up, then a second decision state. Ending
// a stream holds the input off through a decision state and the 12 characters of the
// end-of-file record when nothing is buffered; when a record of n bytes is flushed
// first, its whole sequence comes before them. Output back-pressure stalls the single
// output register and so stretches every hold-off. At the default of 16 bytes a full
// record is 44 characters long.
module intel_hex_record_encoder #(
  parameter int RECORD_BYTES = ihre_pkg::RECORD_BYTES_DEF  // 1 .. 27
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ihre_pkg::ADDR_W-1:0] cfg_wr_data,   // start_address
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [7:0]                  in_tdata,      // [7:0] data_byte
  input  logic [1:0]                  in_tuser,      // [1:0] action
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [7:0]                  out_tdata,     // [7:0] ascii_char
  output logic [0:0]                  out_tuser,     // [0] line_end
  output logic                        out_tlast      // stream_end
);
  import ihre_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  ihre_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .stat      (stat),
    .cmd       (cmd)
  );

  ihre_datapath #(
    .RECORD_BYTES (RECORD_BYTES)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .in_byte        (in_tdata),
    .cmd            (cmd),
    .stat           (stat),
    .out_tvalid     (out_tvalid),
    .out_tready     (out_tready),
    .out_char       (out_tdata),
    .out_line_end   (out_tuser[0]),
    .out_stream_end (out_tlast)
  );

endmodule

[rtl/core/ihre_datapath.sv]
module ihre_datapath #(
  parameter int RECORD_BYTES = ihre_pkg::RECORD_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [ihre_pkg::ADDR_W-1:0] cfg_wr_data,
  input  logic [7:0]                  in_byte,
  input  ihre_pkg::cmd_t              cmd,
  output ihre_pkg::stat_t             stat,
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [ihre_pkg::CHAR_W-1:0] out_char,
  output logic                        out_line_end,
  output logic                        out_stream_end
);
  import ihre_pkg::*;

  localparam int IDX_W = (RECORD_BYTES > 1) ? $clog2(RECORD_BYTES) : 1;

  logic [7:0]        rec_buf_r [RECORD_BYTES];
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [ADDR_W-1:0] start_r, start_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic [7:0]        sum_r, sum_nxt;
  logic              ovalid_r, ovalid_nxt;
  logic [CHAR_W-1:0] ochar_r, ochar_nxt;
  logic              oline_r, oline_nxt;
  logic              oeof_r, oeof_nxt;
  logic [7:0]        cur_byte;
  logic [3:0]        cur_nib;
  logic              out_free;

  assign out_free = !ovalid_r || out_tready;

  // byte under conversion
  always_comb begin
    case (cmd.bsel)
      BS_COUNT:   cur_byte = cmd.eof ? 8'd0 : {{(8-FILL_W){1'b0}}, fill_r};
      BS_ADDR_HI: cur_byte = cmd.eof ? 8'd0 : addr_r[15:8];
      BS_ADDR_LO: cur_byte = cmd.eof ? 8'd0 : addr_r[7:0];
      BS_TYPE:    cur_byte = cmd.eof ? TYPE_EOF : TYPE_DATA;
      BS_DATA:    cur_byte = rec_buf_r[cmd.rd_idx[IDX_W-1:0]];
      BS_SUM:     cur_byte = 8'd0 - sum_r;
      default:    cur_byte = 8'd0;
    endcase
    cur_nib = cmd.nib_hi ? cur_byte[7:4] : cur_byte[3:0];
  end

  // fill, address, checksum, output register
  always_comb begin
    fill_nxt   = fill_r;
    start_nxt  = start_r;
    addr_nxt   = addr_r;
    sum_nxt    = sum_r;
    ovalid_nxt = ovalid_r;
    ochar_nxt  = ochar_r;
    oline_nxt  = oline_r;
    oeof_nxt   = oeof_r;

    if (cfg_wr_en) begin
      start_nxt = cfg_wr_data;
      addr_nxt  = cfg_wr_data;
    end
    if (cmd.push) begin
      fill_nxt = fill_r + FILL_W'(1);
    end
    if (cmd.rec_done) begin
      fill_nxt = '0;
      addr_nxt = addr_r + {{(ADDR_W-FILL_W){1'b0}}, fill_r};
    end
    if (cmd.eof_done) begin
      fill_nxt = '0;
      addr_nxt = start_r;
    end

    if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
    if (cmd.emit) begin
      ovalid_nxt = 1'b1;
      oline_nxt  = 1'b0;
      oeof_nxt   = 1'b0;
      case (cmd.kind)
        CK_COLON: begin
          ochar_nxt = ASCII_COLON;
          sum_nxt   = 8'd0;
        end
        CK_HEX: begin
          ochar_nxt = hex_char(cur_nib);
          if (!cmd.nib_hi && cmd.bsel != BS_SUM) begin
            sum_nxt = sum_r + cur_byte;
          end
        end
        CK_LF: begin
          ochar_nxt = ASCII_LF;
          oline_nxt = 1'b1;
          oeof_nxt  = cmd.eof;
        end
        default: ochar_nxt = ASCII_LF;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      start_r  <= '0;
      addr_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      fill_r   <= fill_nxt;
      start_r  <= start_nxt;
      addr_r   <= addr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    sum_r   <= sum_nxt;
    ochar_r <= ochar_nxt;
    oline_r <= oline_nxt;
    oeof_r  <= oeof_nxt;
    if (cmd.push) begin
      rec_buf_r[fill_r[IDX_W-1:0]] <= in_byte;
    end
  end

  assign stat.out_free  = out_free;
  assign stat.fill_full = (fill_r == FILL_W'(RECORD_BYTES));
  assign stat.fill_last = (fill_r == FILL_W'(RECORD_BYTES - 1));
  assign stat.fill      = fill_r;

  assign out_tvalid     = ovalid_r;
  assign out_char       = ochar_r;
  assign out_line_end   = oline_r;
  assign out_stream_end = oeof_r;

endmodule

[rtl/core/ihre_ctrl.sv]
module ihre_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [1:0]      in_action,
  input  ihre_pkg::stat_t stat,
  output ihre_pkg::cmd_t  cmd
);
  import ihre_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_COLON,
    ST_BODY,
    ST_LF
  } state_t;

  state_t            state_r;
  logic              tail_r;   // stream ends after this request
  logic              eof_r;
  logic              nib_hi_r;
  logic [FILL_W-1:0] pos_r;    // byte position inside the record
  logic              accept;
  logic              push;
  logic              tail;
  logic [FILL_W-1:0] data_end;
  byte_sel_t         bsel;

  assign in_tready = (state_r == ST_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign push      = (action_t'(in_action) == ACT_PUSH) ||
                     (action_t'(in_action) == ACT_PUSH_END);
  assign tail      = (action_t'(in_action) != ACT_PUSH);

  // position of the checksum byte
  assign data_end = FILL_W'(HDR_BYTES) + (eof_r ? FILL_W'(0) : stat.fill);

  always_comb begin
    case (pos_r)
      FILL_W'(0): bsel = BS_COUNT;
      FILL_W'(1): bsel = BS_ADDR_HI;
      FILL_W'(2): bsel = BS_ADDR_LO;
      FILL_W'(3): bsel = BS_TYPE;
      default:    bsel = (pos_r < data_end) ? BS_DATA : BS_SUM;
    endcase
  end

  // commands
  always_comb begin
    cmd          = '0;
    cmd.kind     = CK_HEX;
    cmd.bsel     = bsel;
    cmd.nib_hi   = nib_hi_r;
    cmd.eof      = eof_r;
    cmd.rd_idx   = pos_r - FILL_W'(HDR_BYTES);
    cmd.push     = accept && push;
    case (state_r)
      ST_COLON: begin
        cmd.kind = CK_COLON;
        cmd.emit = stat.out_free;
      end
      ST_BODY: cmd.emit = stat.out_free;
      ST_LF: begin
        cmd.kind     = CK_LF;
        cmd.emit     = stat.out_free;
        cmd.rec_done = stat.out_free && !eof_r;
        cmd.eof_done = stat.out_free && eof_r;
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      tail_r   <= 1'b0;
      eof_r    <= 1'b0;
      nib_hi_r <= 1'b1;
      pos_r    <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            tail_r <= tail;
            if (tail || stat.fill_last) begin
              state_r <= ST_DECIDE;
            end
          end
        end
        ST_DECIDE: begin
          if (stat.fill_full || (tail_r && stat.fill != '0)) begin
            eof_r   <= 1'b0;
            state_r <= ST_COLON;
          end else if (tail_r) begin
            eof_r   <= 1'b1;
            state_r <= ST_COLON;
          end else begin
            state_r <= ST_IDLE;
          end
        end
        ST_COLON: begin
          if (stat.out_free) begin
            pos_r    <= '0;
            nib_hi_r <= 1'b1;
            state_r  <= ST_BODY;
          end
        end
        ST_BODY: begin
          if (stat.out_free) begin
            if (nib_hi_r) begin
              nib_hi_r <= 1'b0;
            end else begin
              nib_hi_r <= 1'b1;
              pos_r    <= pos_r + FILL_W'(1);
              if (bsel == BS_SUM) begin
                state_r <= ST_LF;
              end
            end
          end
        end
        ST_LF: begin
          if (stat.out_free) begin
            if (eof_r) begin
              tail_r  <= 1'b0;
              state_r <= ST_IDLE;
            end else begin
              state_r <= ST_DECIDE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps

module testbench;

  localparam int REC_LEN       = ihre_pkg::RECORD_BYTES_DEF;
  localparam int SETTLE_CYCLES = 40;   // well past a one-cycle push
  localparam int LONG_HOLD     = 300;  // receiver hold-off for the pressure test
  localparam int MAX_REPORTS   = 50;

  // action code 3 is decoded like a plain end of stream
  localparam logic [1:0] ACT_END_ALT = 2'd3;

  // one character of expected Intel HEX text
  typedef struct packed {
    logic [7:0] ch;
    logic       line_end;
    logic       stream_end;
  } text_char_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;
  logic [0:0]  out_tuser;
  logic        out_tlast;

  // predictor state
  logic [7:0]  rec_buf [REC_LEN];
  int          fill_cnt;
  logic [15:0] cur_addr;
  logic [15:0] start_addr;
  text_char_t  exp_text_q[$];

  int src_idle_pct;
  int snk_idle_pct;
  int hold_req;
  int err_cnt;
  int req_count;

  intel_hex_record_encoder #(
    .RECORD_BYTES(REC_LEN)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Text predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] nibble_ascii(input logic [3:0] nib);
    return (nib > 4'd9) ? 8'd65 + 8'(nib - 4'd10) : 8'd48 + 8'(nib);
  endfunction

  function automatic void queue_char(input logic [7:0] c, input logic le, input logic se);
    text_char_t t;
    t.ch = c;
    t.line_end = le;
    t.stream_end = se;
    exp_text_q.push_back(t);
  endfunction

  function automatic void queue_hex_byte(input logic [7:0] b);
    queue_char(nibble_ascii(b[7:4]), 1'b0, 1'b0);
    queue_char(nibble_ascii(b[3:0]), 1'b0, 1'b0);
  endfunction

  // count 0 with eof set gives the end-of-file record
  function automatic void queue_record(input int cnt, input logic eof);
    logic [7:0] hi, lo, kind, sum;
    hi   = eof ? 8'h00 : cur_addr[15:8];
    lo   = eof ? 8'h00 : cur_addr[7:0];
    kind = eof ? ihre_pkg::TYPE_EOF : ihre_pkg::TYPE_DATA;
    sum  = 8'(cnt) + hi + lo + kind;
    queue_char(ihre_pkg::ASCII_COLON, 1'b0, 1'b0);
    queue_hex_byte(8'(cnt));
    queue_hex_byte(hi);
    queue_hex_byte(lo);
    queue_hex_byte(kind);
    for (int i = 0; i < cnt; i++) begin
      queue_hex_byte(rec_buf[i]);
      sum = sum + rec_buf[i];
    end
    queue_hex_byte(8'h00 - sum);
    queue_char(ihre_pkg::ASCII_LF, 1'b1, eof);
    if (!eof) begin
      cur_addr = cur_addr + 16'(cnt);
    end
  endfunction

  function automatic void predict_request(input logic [1:0] act, input logic [7:0] b);
    if (act == ihre_pkg::ACT_PUSH || act == ihre_pkg::ACT_PUSH_END) begin
      rec_buf[fill_cnt] = b;
      fill_cnt++;
      if (fill_cnt == REC_LEN) begin
        queue_record(REC_LEN, 1'b0);
        fill_cnt = 0;
      end
    end
    if (act != ihre_pkg::ACT_PUSH) begin
      if (fill_cnt > 0) begin
        queue_record(fill_cnt, 1'b0);
      end
      queue_record(0, 1'b1);
      fill_cnt = 0;
      cur_addr = start_addr;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Expectations are queued as soon as the request is offered: it stays
  // offered, unchanged, until taken, so its text is always queued ahead of it.
  task automatic send_req(input logic [1:0] act, input logic [7:0] b);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= act;
    in_tdata  <= b;
    predict_request(act, b);
    @(posedge clk);
    while (!in_tready) begin
      @(posedge clk);
    end
    req_count++;
  endtask

  // drop the request line and let all expected text drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (exp_text_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_start_addr(input logic [15:0] addr);
    settle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= addr;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    start_addr = addr;
    cur_addr   = addr;
  endtask

  // random streams of random bytes, occasional reconfiguration
  task automatic run_streams(input int n_items);
    int         sent;
    int         len;
    int         cut;
    logic       tail;
    logic [15:0] addr;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(2) == 0) begin
        case ($urandom_range(4))
          0: addr = 16'h0000;
          1: addr = 16'hFFFF;
          2: addr = 16'hFFF0 + 16'($urandom_range(15));
          default: addr = 16'($urandom);
        endcase
        write_start_addr(addr);
      end
      case ($urandom_range(5))
        0: len = 0;
        1: len = REC_LEN;
        2: len = 2 * REC_LEN + $urandom_range(3);
        default: len = $urandom_range(REC_LEN + 4, 1);
      endcase
      // sometimes rewrite the address with a partial record buffered
      cut  = ($urandom_range(7) == 0) ? $urandom_range(len) : -1;
      tail = (len > 0) && ($urandom_range(1) == 1);
      for (int i = 0; i < len; i++) begin
        if (i == cut && i != 0) begin
          write_start_addr(16'($urandom));
        end
        if (i == len - 1 && tail) begin
          send_req(ihre_pkg::ACT_PUSH_END, 8'($urandom_range(255)));
        end else begin
          send_req(ihre_pkg::ACT_PUSH, 8'($urandom_range(255)));
        end
        sent++;
      end
      if (!tail) begin
        send_req(($urandom_range(1) == 1) ? ihre_pkg::ACT_END : ACT_END_ALT,
                 8'($urandom_range(255)));
        sent++;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_directed();
    src_idle_pct = 13;
    snk_idle_pct = 66;
    // empty stream ends, byte lines ignored
    send_req(ihre_pkg::ACT_END, 8'hFF);
    send_req(ACT_END_ALT, 8'h00);
    // short partial record
    send_req(ihre_pkg::ACT_PUSH, 8'h00);
    send_req(ihre_pkg::ACT_PUSH_END, 8'hFF);
    // stream ending on a full record
    for (int i = 0; i < REC_LEN; i++) begin
      send_req((i == REC_LEN - 1) ? ihre_pkg::ACT_PUSH_END : ihre_pkg::ACT_PUSH,
               8'(i * 17));
    end
    // address rewrite with bytes buffered: buffer kept, address reloaded
    send_req(ihre_pkg::ACT_PUSH, 8'hA5);
    send_req(ihre_pkg::ACT_PUSH, 8'h5A);
    write_start_addr(16'h1234);
    send_req(ihre_pkg::ACT_PUSH_END, 8'h80);
    // top of the address space
    write_start_addr(16'hFFFF);
    send_req(ihre_pkg::ACT_PUSH_END, 8'h01);
    settle();
  endtask

  task automatic test_random_streams();
    src_idle_pct = 13;
    snk_idle_pct = 66;
    run_streams(25);
    settle();
    src_idle_pct = 66;
    snk_idle_pct = 13;
    run_streams(25);
    settle();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_start_addr(16'h0000);
    run_streams(25);
    settle();
  endtask

  // receiver holds off while the sender keeps offering bytes
  task automatic test_backpressure();
    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_start_addr(16'hFFF8);
    hold_req++;
    for (int i = 0; i < 40; i++) begin
      send_req((i == 39) ? ihre_pkg::ACT_PUSH_END : ihre_pkg::ACT_PUSH,
               8'($urandom_range(255)));
    end
    settle();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver: random ready, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  initial begin
    int hold_left;
    int hold_ack;
    hold_left  = 0;
    hold_ack   = 0;
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_ack != hold_req) begin
        hold_ack  = hold_req;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else begin
        out_tready <= ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Text checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    text_char_t exp_c;
    if (rst_n && out_tvalid && out_tready) begin
      if (exp_text_q.size() == 0) begin
        if (err_cnt < MAX_REPORTS) begin
          $display("%0t: unexpected char exp none got %02h le %0b se %0b",
                   $time, out_tdata, out_tuser[0], out_tlast);
        end
        err_cnt++;
      end else begin
        exp_c = exp_text_q.pop_front();
        if (out_tdata !== exp_c.ch) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("%0t: ascii_char exp %02h got %02h", $time, exp_c.ch, out_tdata);
          end
          err_cnt++;
        end
        if (out_tuser[0] !== exp_c.line_end) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("%0t: line_end exp %0b got %0b", $time, exp_c.line_end, out_tuser[0]);
          end
          err_cnt++;
        end
        if (out_tlast !== exp_c.stream_end) begin
          if (err_cnt < MAX_REPORTS) begin
            $display("%0t: stream_end exp %0b got %0b", $time, exp_c.stream_end, out_tlast);
          end
          err_cnt++;
        end
      end
    end
  end

  // run limit
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n        = 1'b0;
    cfg_wr_en    = 1'b0;
    cfg_wr_data  = 16'h0000;
    in_tvalid    = 1'b0;
    in_tdata     = 8'h00;
    in_tuser     = ihre_pkg::ACT_PUSH;
    src_idle_pct = 0;
    snk_idle_pct = 0;
    hold_req     = 0;
    err_cnt      = 0;
    req_count    = 0;
    fill_cnt     = 0;
    cur_addr     = 16'h0000;
    start_addr   = 16'h0000;
    for (int i = 0; i < REC_LEN; i++) begin
      rec_buf[i] = 8'h00;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random_streams();
    test_backpressure();

    settle();
    if (err_cnt == 0 && exp_text_q.size() == 0) begin
      $display("Regression PASS");
    end else begin
      if (exp_text_q.size() != 0) begin
        $display("%0t: %0d expected chars never arrived", $time, exp_text_q.size());
      end
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/ihre_pkg.sv
rtl/core/ihre_datapath.sv
rtl/core/ihre_ctrl.sv
rtl/core/intel_hex_record_encoder.sv
verif/testbench.sv
